// File: design/channel_segment_manning_flow_unit_defines.svh
// Assertion helpers used by csmf_core.
`ifndef CHANNEL_SEGMENT_MANNING_FLOW_UNIT_DEFINES_SVH
`define CHANNEL_SEGMENT_MANNING_FLOW_UNIT_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define CSMF_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// When pre holds, post must hold in the following cycle.
`define CSMF_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

// File: design/csmf_pkg.sv
`default_nettype none
package csmf_pkg;

   typedef enum logic [2:0] {
      CSR_CORE_HALF_EXTENT  = 3'd0,
      CSR_INVERSE_ROUGHNESS = 3'd1,
      CSR_SLOPE_FLOOR       = 3'd2,
      CSR_VELOCITY_FLOOR    = 3'd3,
      CSR_VELOCITY_CEILING  = 3'd4
   } csr_index_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 31;

   localparam logic [30:0] RST_CORE_HALF_EXTENT  = 31'd262144;
   localparam logic [15:0] RST_INVERSE_ROUGHNESS = 16'd8533;
   localparam logic [23:0] RST_SLOPE_FLOOR       = 24'd0;
   localparam logic [15:0] RST_VELOCITY_FLOOR    = 16'd0;
   localparam logic [15:0] RST_VELOCITY_CEILING  = 16'd65535;

   typedef struct packed {
      logic [30:0] core_half_extent;
      logic [15:0] inverse_roughness;
      logic [23:0] slope_floor;
      logic [15:0] velocity_floor;
      logic [15:0] velocity_ceiling;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] up_x;
      logic signed [31:0] up_y;
      logic signed [31:0] down_x;
      logic signed [31:0] down_y;
      logic signed [23:0] up_bed;
      logic signed [23:0] down_bed;
      logic [15:0]        up_depth;
      logic [15:0]        down_depth;
      logic [15:0]        up_half_width;
      logic [15:0]        down_half_width;
   } req_type;

   typedef struct packed {
      logic        owned;
      logic [23:0] bed_slope;
      logic [15:0] flow_velocity;
   } rsp_type;

   // length root: 64-bit radicand, 32-bit root
   typedef struct packed {
      logic [63:0] sr;
      logic [33:0] rem;
      logic [31:0] root;
   } lsq_type;

   // velocity root: 40-bit radicand, 20-bit root
   typedef struct packed {
      logic [39:0] sr;
      logic [21:0] rem;
      logic [19:0] root;
   } qsq_type;

   // hydraulic radius divide, 18-bit divisor
   typedef struct packed {
      logic [23:0] sr;
      logic [17:0] rem;
      logic [23:0] q;
   } rqd_type;

   // slope divide, 33-bit divisor
   typedef struct packed {
      logic [23:0] sr;
      logic [32:0] rem;
      logic [23:0] q;
   } sdv_type;

   // cube root, 64-bit radicand padded to 66
   typedef struct packed {
      logic [65:0] sr;
      logic [46:0] rem;
      logic [21:0] y;
      logic [43:0] sq;
   } cbt_type;

   // pipeline schedule
   localparam int NUM_STAGES     = 26;
   localparam int ST_MUL         = 1;
   localparam int ST_INIT        = 2;
   localparam int ST_LSQ_FIRST   = 3;
   localparam int ST_LSQ_LAST    = 10;
   localparam int LSQ_PER_STAGE  = 4;
   localparam int ST_RQD_FIRST   = 3;
   localparam int ST_RQD_LAST    = 8;
   localparam int RQD_PER_STAGE  = 4;
   localparam int ST_RQSQ        = 9;
   localparam int ST_CBT_FIRST   = 10;
   localparam int ST_CBT_LAST    = 20;
   localparam int CBT_PER_STAGE  = 2;
   localparam int ST_LEN         = 11;
   localparam int ST_SDV_FIRST   = 12;
   localparam int ST_SDV_LAST    = 17;
   localparam int SDV_PER_STAGE  = 4;
   localparam int ST_SLOPE       = 18;
   localparam int ST_QSQ_FIRST   = 19;
   localparam int ST_QSQ_LAST    = 23;
   localparam int QSQ_PER_STAGE  = 4;
   localparam int ST_MUL_P       = 21;
   localparam int ST_MUL_Q       = 24;
   localparam int ST_CLAMP       = 25;

   typedef struct packed {
      logic               owned;
      logic               sh;
      logic signed [24:0] drop;
      logic               zero_ws;
      logic [16:0]        w;
      logic [16:0]        s2;
      logic [30:0]        ax;
      logic [30:0]        ay;
      logic [61:0]        sqx;
      logic [61:0]        sqy;
      logic [33:0]        ws;
      logic [17:0]        den;
      lsq_type            lsq;
      rqd_type            rqd;
      logic [47:0]        rq2;
      cbt_type            cbt;
      logic [32:0]        len;
      logic               s_zero;
      logic               s_sat;
      sdv_type            sdv;
      logic [23:0]        slope;
      qsq_type            qsq;
      logic [37:0]        m1;
      logic [57:0]        m2;
      logic [15:0]        vel;
   } pipe_type;

   function automatic lsq_type lsq_step(lsq_type s);
      lsq_type     n;
      logic [35:0] r2;
      logic [35:0] t;
      n  = s;
      r2 = {s.rem, s.sr[63:62]};
      t  = {2'b00, s.root, 2'b01};
      if (r2 >= t) begin
         n.rem  = 34'(r2 - t);
         n.root = {s.root[30:0], 1'b1};
      end else begin
         n.rem  = r2[33:0];
         n.root = {s.root[30:0], 1'b0};
      end
      n.sr = {s.sr[61:0], 2'b00};
      return n;
   endfunction

   function automatic qsq_type qsq_step(qsq_type s);
      qsq_type     n;
      logic [23:0] r2;
      logic [23:0] t;
      n  = s;
      r2 = {s.rem, s.sr[39:38]};
      t  = {2'b00, s.root, 2'b01};
      if (r2 >= t) begin
         n.rem  = 22'(r2 - t);
         n.root = {s.root[18:0], 1'b1};
      end else begin
         n.rem  = r2[21:0];
         n.root = {s.root[18:0], 1'b0};
      end
      n.sr = {s.sr[37:0], 2'b00};
      return n;
   endfunction

   function automatic rqd_type rqd_step(rqd_type s, logic [17:0] d);
      rqd_type     n;
      logic [18:0] r2;
      n  = s;
      r2 = {s.rem, s.sr[23]};
      if (r2 >= {1'b0, d}) begin
         n.rem = 18'(r2 - {1'b0, d});
         n.q   = {s.q[22:0], 1'b1};
      end else begin
         n.rem = r2[17:0];
         n.q   = {s.q[22:0], 1'b0};
      end
      n.sr = {s.sr[22:0], 1'b0};
      return n;
   endfunction

   function automatic sdv_type sdv_step(sdv_type s, logic [32:0] d);
      sdv_type     n;
      logic [33:0] r2;
      n  = s;
      r2 = {s.rem, s.sr[23]};
      if (r2 >= {1'b0, d}) begin
         n.rem = 33'(r2 - {1'b0, d});
         n.q   = {s.q[22:0], 1'b1};
      end else begin
         n.rem = r2[32:0];
         n.q   = {s.q[22:0], 1'b0};
      end
      n.sr = {s.sr[22:0], 1'b0};
      return n;
   endfunction

   // b = 3y^2 + 3y + 1 built from the running square, adds only
   function automatic cbt_type cbt_step(cbt_type s);
      cbt_type     n;
      logic [21:0] y2;
      logic [43:0] sq2;
      logic [45:0] b;
      logic [49:0] r2;
      n   = s;
      y2  = {s.y[20:0], 1'b0};
      sq2 = {s.sq[41:0], 2'b00};
      b   = {2'b00, sq2} + {1'b0, sq2, 1'b0} + {24'd0, y2} + {23'd0, y2, 1'b0} + 46'd1;
      r2  = {s.rem, s.sr[65:63]};
      if (r2 >= {4'd0, b}) begin
         n.rem = 47'(r2 - {4'd0, b});
         n.y   = y2 + 22'd1;
         n.sq  = sq2 + {21'd0, y2, 1'b0} + 44'd1;
      end else begin
         n.rem = r2[46:0];
         n.y   = y2;
         n.sq  = sq2;
      end
      n.sr = {s.sr[62:0], 3'b000};
      return n;
   endfunction

endpackage
`default_nettype wire

// File: design/csmf_if.sv
`default_nettype none
interface csmf_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] up_x;
   logic signed [31:0] up_y;
   logic signed [31:0] down_x;
   logic signed [31:0] down_y;
   logic signed [23:0] up_bed;
   logic signed [23:0] down_bed;
   logic [15:0]        up_depth;
   logic [15:0]        down_depth;
   logic [15:0]        up_half_width;
   logic [15:0]        down_half_width;

   modport source (output valid, up_x, up_y, down_x, down_y, up_bed, down_bed,
                   up_depth, down_depth, up_half_width, down_half_width,
                   input ready);
   modport sink (input valid, up_x, up_y, down_x, down_y, up_bed, down_bed,
                 up_depth, down_depth, up_half_width, down_half_width,
                 output ready);
endinterface

interface csmf_rsp_if;
   logic        valid;
   logic        ready;
   logic        owned;
   logic [23:0] bed_slope;
   logic [15:0] flow_velocity;

   modport source (output valid, owned, bed_slope, flow_velocity, input ready);
   modport sink (input valid, owned, bed_slope, flow_velocity, output ready);
endinterface
`default_nettype wire

// File: design/csmf_core.sv
`default_nettype none
`include "channel_segment_manning_flow_unit_defines.svh"
module csmf_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire csmf_pkg::cfg_type  cfg,
   input  wire logic               in_valid,
   input  wire csmf_pkg::req_type  in_data,
   output logic                    in_ready,
   output logic                    out_valid,
   output csmf_pkg::rsp_type       out_data,
   input  wire logic               out_ready
);
   import csmf_pkg::*;

   pipe_type               pipe_ff [NUM_STAGES];
   pipe_type               pipe_in [NUM_STAGES];
   logic [NUM_STAGES-1:0]  valid_ff;
   logic                   adv;

   // whole pipe moves together; last stage is the output register
   assign adv      = !valid_ff[NUM_STAGES-1] || out_ready;
   assign in_ready = adv;

   // entry stage: sums, magnitudes, ownership
   always_comb begin
      pipe_type           n;
      logic signed [32:0] sx, sy, dfx, dfy;
      logic [32:0]        mx, my, adx, ady;
      logic [32:0]        lim;
      n   = '0;
      sx  = {in_data.up_x[31], in_data.up_x} + {in_data.down_x[31], in_data.down_x};
      sy  = {in_data.up_y[31], in_data.up_y} + {in_data.down_y[31], in_data.down_y};
      dfx = {in_data.up_x[31], in_data.up_x} - {in_data.down_x[31], in_data.down_x};
      dfy = {in_data.up_y[31], in_data.up_y} - {in_data.down_y[31], in_data.down_y};
      mx  = sx[32] ? 33'(-sx) : 33'(sx);
      my  = sy[32] ? 33'(-sy) : 33'(sy);
      adx = dfx[32] ? 33'(-dfx) : 33'(dfx);
      ady = dfy[32] ? 33'(-dfy) : 33'(dfy);
      lim = {1'b0, cfg.core_half_extent, 1'b0};
      n.owned = (mx <= lim) && (my <= lim);
      n.sh    = (adx[32:31] != 2'b00) || (ady[32:31] != 2'b00);
      n.ax    = n.sh ? adx[31:1] : adx[30:0];
      n.ay    = n.sh ? ady[31:1] : ady[30:0];
      n.drop  = {in_data.up_bed[23], in_data.up_bed}
              - {in_data.down_bed[23], in_data.down_bed};
      n.w     = {1'b0, in_data.up_half_width} + {1'b0, in_data.down_half_width};
      n.s2    = {1'b0, in_data.up_depth} + {1'b0, in_data.down_depth};
      n.zero_ws = (n.w == 17'd0) || (n.s2 == 17'd0);
      pipe_in[0] = n;
   end

   for (genvar k = 1; k < NUM_STAGES; k++) begin : g_stage
      always_comb begin
         pipe_type    n;
         logic [25:0] v;
         logic [25:0] vf;
         n = pipe_ff[k-1];
         v  = n.m2[57:32];
         vf = '0;
         if (k == ST_MUL) begin
            n.sqx = n.ax * n.ax;
            n.sqy = n.ay * n.ay;
            n.ws  = n.w * n.s2;
         end
         if (k == ST_INIT) begin
            n.lsq.sr   = {1'b0, 63'({1'b0, n.sqx} + {1'b0, n.sqy})};
            n.lsq.rem  = '0;
            n.lsq.root = '0;
            n.den      = {1'b0, n.w} + {1'b0, n.s2};
            n.rqd.rem  = {1'b0, n.ws[33:17]};
            n.rqd.sr   = {n.ws[16:0], 7'd0};
            n.rqd.q    = '0;
         end
         if (k >= ST_LSQ_FIRST && k <= ST_LSQ_LAST) begin
            for (int i = 0; i < LSQ_PER_STAGE; i++) n.lsq = lsq_step(n.lsq);
         end
         if (k >= ST_RQD_FIRST && k <= ST_RQD_LAST) begin
            for (int i = 0; i < RQD_PER_STAGE; i++) n.rqd = rqd_step(n.rqd, n.den);
         end
         if (k == ST_RQSQ) n.rq2 = n.rqd.q * n.rqd.q;
         if (k == ST_CBT_FIRST) begin
            n.cbt.sr  = {2'b00, n.rq2, 16'd0};
            n.cbt.rem = '0;
            n.cbt.y   = '0;
            n.cbt.sq  = '0;
         end
         if (k >= ST_CBT_FIRST && k <= ST_CBT_LAST) begin
            for (int i = 0; i < CBT_PER_STAGE; i++) n.cbt = cbt_step(n.cbt);
         end
         if (k == ST_LEN) begin
            n.len    = n.sh ? {n.lsq.root, 1'b0} : {1'b0, n.lsq.root};
            n.s_zero = (n.drop <= 25'sd0) || (n.len == 33'd0);
            n.s_sat  = {17'd0, n.drop[23:0]} >= {n.len, 8'd0};
            n.sdv.rem = {17'd0, n.drop[23:8]};
            n.sdv.sr  = {n.drop[7:0], 16'd0};
            n.sdv.q   = '0;
         end
         if (k >= ST_SDV_FIRST && k <= ST_SDV_LAST) begin
            for (int i = 0; i < SDV_PER_STAGE; i++) n.sdv = sdv_step(n.sdv, n.len);
         end
         if (k == ST_SLOPE) begin
            n.slope = n.s_zero ? 24'd0 : (n.s_sat ? 24'hFFFFFF : n.sdv.q);
            n.qsq.sr   = {((n.slope > cfg.slope_floor) ? n.slope : cfg.slope_floor), 16'd0};
            n.qsq.rem  = '0;
            n.qsq.root = '0;
         end
         if (k >= ST_QSQ_FIRST && k <= ST_QSQ_LAST) begin
            for (int i = 0; i < QSQ_PER_STAGE; i++) n.qsq = qsq_step(n.qsq);
         end
         if (k == ST_MUL_P) n.m1 = cfg.inverse_roughness * n.cbt.y;
         if (k == ST_MUL_Q) n.m2 = n.m1 * n.qsq.root;
         if (k == ST_CLAMP) begin
            vf = (v < {10'd0, cfg.velocity_floor}) ? {10'd0, cfg.velocity_floor} : v;
            if (!n.owned) begin
               n.vel   = '0;
               n.slope = '0;
            end else if (n.zero_ws) begin
               n.vel = cfg.velocity_floor;
            end else if (vf > {10'd0, cfg.velocity_ceiling}) begin
               n.vel = cfg.velocity_ceiling;
            end else begin
               n.vel = vf[15:0];
            end
         end
         pipe_in[k] = n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[NUM_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NUM_STAGES; k++) pipe_ff[k] <= pipe_in[k];
      end
   end

   assign out_valid              = valid_ff[NUM_STAGES-1];
   assign out_data.owned         = pipe_ff[NUM_STAGES-1].owned;
   assign out_data.bed_slope     = pipe_ff[NUM_STAGES-1].slope;
   assign out_data.flow_velocity = pipe_ff[NUM_STAGES-1].vel;

   `CSMF_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, valid_ff[0], "accepted request lost at entry")
   `CSMF_ASSERT_NEXT(a_stall_holds, !in_ready, $stable(valid_ff), "pipe moved during stall")
   `CSMF_ASSERT_ALWAYS(a_unowned_zero, out_valid && !out_data.owned |-> out_data.bed_slope == 24'd0 && out_data.flow_velocity == 16'd0, "unowned segment with nonzero result")
   `CSMF_ASSERT_ALWAYS(a_vel_range, out_valid && out_data.owned && !pipe_ff[NUM_STAGES-1].zero_ws && cfg.velocity_floor <= cfg.velocity_ceiling |-> out_data.flow_velocity >= cfg.velocity_floor && out_data.flow_velocity <= cfg.velocity_ceiling, "velocity outside clamp window")

endmodule
`default_nettype wire

// File: design/channel_segment_manning_flow_unit.sv
`default_nettype none
// Channel segment flow unit. Each request is one channel segment (two end nodes with
// position, bed elevation, water depth and half width); each request yields exactly one
// response: ownership of the midpoint in the core square, the Q8.16 bed slope, and the
// clamped Manning velocity in 1/256 m/s. The unit is a 26-stage pipeline that takes one
// request per clock when not stalled; the depth is set by the digit-by-digit units spread
// over the stages: the 32-bit length root (four digits a stage), the hydraulic-radius and
// slope dividers (four quotient bits a stage), the cube root (two digits a stage) and the
// 20-bit slope root. A stalled response holds the whole pipe, so nothing is dropped. The
// user must write registers through csr_we/csr_index/csr_wdata only while no request is in
// flight; the block itself does not enforce this. Unknown indexes are ignored.
module channel_segment_manning_flow_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   csmf_req_if.sink                               req_ch,
   csmf_rsp_if.source                             rsp_ch,
   input  wire logic                              csr_we,
   input  wire logic [csmf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [csmf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import csmf_pkg::*;

   cfg_type cfg_ff;
   req_type req_data;
   rsp_type rsp_data;

   // register file; writes outside the map fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.core_half_extent  <= RST_CORE_HALF_EXTENT;
         cfg_ff.inverse_roughness <= RST_INVERSE_ROUGHNESS;
         cfg_ff.slope_floor       <= RST_SLOPE_FLOOR;
         cfg_ff.velocity_floor    <= RST_VELOCITY_FLOOR;
         cfg_ff.velocity_ceiling  <= RST_VELOCITY_CEILING;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CORE_HALF_EXTENT:  cfg_ff.core_half_extent  <= csr_wdata[30:0];
            CSR_INVERSE_ROUGHNESS: cfg_ff.inverse_roughness <= csr_wdata[15:0];
            CSR_SLOPE_FLOOR:       cfg_ff.slope_floor       <= csr_wdata[23:0];
            CSR_VELOCITY_FLOOR:    cfg_ff.velocity_floor    <= csr_wdata[15:0];
            CSR_VELOCITY_CEILING:  cfg_ff.velocity_ceiling  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // request payload into the pipe's struct
   assign req_data.up_x            = req_ch.up_x;
   assign req_data.up_y            = req_ch.up_y;
   assign req_data.down_x          = req_ch.down_x;
   assign req_data.down_y          = req_ch.down_y;
   assign req_data.up_bed          = req_ch.up_bed;
   assign req_data.down_bed        = req_ch.down_bed;
   assign req_data.up_depth        = req_ch.up_depth;
   assign req_data.down_depth      = req_ch.down_depth;
   assign req_data.up_half_width   = req_ch.up_half_width;
   assign req_data.down_half_width = req_ch.down_half_width;

   csmf_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_ch.valid),
      .in_data   (req_data),
      .in_ready  (req_ch.ready),
      .out_valid (rsp_ch.valid),
      .out_data  (rsp_data),
      .out_ready (rsp_ch.ready)
   );

   assign rsp_ch.owned         = rsp_data.owned;
   assign rsp_ch.bed_slope     = rsp_data.bed_slope;
   assign rsp_ch.flow_velocity = rsp_data.flow_velocity;

endmodule
`default_nettype wire
